FILE: hw/rtl/suffix_automaton_builder_unit_defines.svh
// Assertion macros shared by the checker of the suffix automaton builder.
// No dependencies.
`ifndef SUFFIX_AUTOMATON_BUILDER_UNIT_DEFINES_SVH
`define SUFFIX_AUTOMATON_BUILDER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SAB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sab assertion failed");

// Next-cycle implication, disabled during reset.
`define SAB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sab assertion failed");

`endif

FILE: hw/rtl/sab_pkg.sv
// Package of the suffix automaton builder: command codes and the result record.
// No dependencies.
package sab_pkg;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam int RESULT_BYTES = 3;

    typedef struct packed {
        logic [7:0] states_used;
        logic [7:0] match_len;
        logic       found;
        logic       accepted;
    } sab_result_t;

endpackage

FILE: hw/rtl/sab_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module sab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/sab_seq.sv
// Sequencer of the suffix automaton builder: owns the transition, length and
// link memories and walks them step by step. Depends on sab_pkg, sab_ram.
module sab_seq
    import sab_pkg::*;
#(
    parameter int MAX_STATES  = 128,
    parameter int SYMBOL_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  in_cmd,
    input  logic [7:0]  in_symbol,
    input  logic        in_qend,
    output logic        res_valid,
    input  logic        res_ready,
    output sab_result_t res
);

    localparam int IDX_W  = $clog2(MAX_STATES);
    localparam int ADDR_W = IDX_W + SYMBOL_BITS;
    localparam int TW     = IDX_W + 1;
    localparam int ALPHA  = 1 << SYMBOL_BITS;
    localparam int TDEPTH = 1 << ADDR_W;
    localparam int LDEPTH = 1 << IDX_W;

    localparam logic [4:0] S_CLR    = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_A_SET  = 5'd2;
    localparam logic [4:0] S_W_RD   = 5'd3;
    localparam logic [4:0] S_W_CHK  = 5'd4;
    localparam logic [4:0] S_F_LP   = 5'd5;
    localparam logic [4:0] S_F_LQ   = 5'd6;
    localparam logic [4:0] S_F_CMP  = 5'd7;
    localparam logic [4:0] S_C_LINK = 5'd8;
    localparam logic [4:0] S_C_COPY = 5'd9;
    localparam logic [4:0] S_R_RD   = 5'd10;
    localparam logic [4:0] S_R_CHK  = 5'd11;
    localparam logic [4:0] S_C_FIX  = 5'd12;
    localparam logic [4:0] S_C_FIX2 = 5'd13;
    localparam logic [4:0] S_FIN    = 5'd14;
    localparam logic [4:0] S_Q_CHK  = 5'd15;
    localparam logic [4:0] S_DONE   = 5'd16;

    logic [4:0]             st_reg, st_next;
    logic [ADDR_W:0]        cnt_reg, cnt_next;
    logic                   clr_resp_reg, clr_resp_next;
    logic [SYMBOL_BITS-1:0] sym_reg, sym_next;
    logic                   qend_reg, qend_next;
    logic [IDX_W-1:0]       last_reg, last_next;
    logic [IDX_W:0]         total_reg, total_next;
    logic [IDX_W-1:0]       cur_reg, cur_next;
    logic [IDX_W-1:0]       p_reg, p_next;
    logic [IDX_W-1:0]       q_reg, q_next;
    logic [IDX_W-1:0]       clone_reg, clone_next;
    logic [IDX_W-1:0]       lenp_reg, lenp_next;
    logic [IDX_W-1:0]       cursor_reg, cursor_next;
    logic                   failed_reg, failed_next;
    logic [7:0]             qcount_reg, qcount_next;
    sab_result_t            res_reg, res_next;

    logic              t_we;
    logic [ADDR_W-1:0] t_waddr, t_raddr;
    logic [TW-1:0]     t_wdata, t_rdata;
    logic              l_we;
    logic [IDX_W-1:0]  l_waddr, l_raddr, l_wdata, l_rdata;
    logic              k_we;
    logic [IDX_W-1:0]  k_waddr, k_raddr, k_wdata, k_rdata;

    logic [IDX_W-1:0] q_cursor;
    logic             q_failed;
    logic [7:0]       q_count;

    sab_ram #(.WIDTH(TW), .DEPTH(TDEPTH)) u_trans (
        .aclk(aclk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(t_raddr), .rdata(t_rdata)
    );

    sab_ram #(.WIDTH(IDX_W), .DEPTH(LDEPTH)) u_len (
        .aclk(aclk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
        .raddr(l_raddr), .rdata(l_rdata)
    );

    sab_ram #(.WIDTH(IDX_W), .DEPTH(LDEPTH)) u_link (
        .aclk(aclk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
        .raddr(k_raddr), .rdata(k_rdata)
    );

    always_comb begin
        st_next       = st_reg;
        cnt_next      = cnt_reg;
        clr_resp_next = clr_resp_reg;
        sym_next      = sym_reg;
        qend_next     = qend_reg;
        last_next     = last_reg;
        total_next    = total_reg;
        cur_next      = cur_reg;
        p_next        = p_reg;
        q_next        = q_reg;
        clone_next    = clone_reg;
        lenp_next     = lenp_reg;
        cursor_next   = cursor_reg;
        failed_next   = failed_reg;
        qcount_next   = qcount_reg;
        res_next      = res_reg;
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        t_we          = 1'b0;
        t_waddr       = {p_reg, sym_reg};
        t_wdata       = '0;
        t_raddr       = {p_reg, sym_reg};
        l_we          = 1'b0;
        l_waddr       = cur_reg;
        l_wdata       = '0;
        l_raddr       = p_reg;
        k_we          = 1'b0;
        k_waddr       = cur_reg;
        k_wdata       = '0;
        k_raddr       = p_reg;
        q_cursor      = cursor_reg;
        q_failed      = failed_reg;
        q_count       = qcount_reg;

        unique case (st_reg)
            S_CLR: begin
                t_we    = 1'b1;
                t_waddr = cnt_reg[ADDR_W-1:0];
                l_we    = 1'b1;
                l_waddr = '0;
                k_we    = 1'b1;
                k_waddr = '0;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[ADDR_W-1:0] == {ADDR_W{1'b1}}) begin
                    if (clr_resp_reg) begin
                        res_next = '{states_used: 8'(total_reg), match_len: 8'd0,
                                     found: 1'b0, accepted: 1'b1};
                        st_next = S_DONE;
                    end else begin
                        st_next = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                in_ready = 1'b1;
                t_raddr  = {cursor_reg, in_symbol[SYMBOL_BITS-1:0]};
                l_raddr  = last_reg;
                if (in_valid) begin
                    sym_next  = in_symbol[SYMBOL_BITS-1:0];
                    qend_next = in_qend;
                    if (in_cmd == CMD_APPEND) begin
                        if ({1'b0, total_reg} + (IDX_W + 2)'(2) >
                            (IDX_W + 2)'(MAX_STATES)) begin
                            res_next = '{states_used: 8'(total_reg), match_len: qcount_reg,
                                         found: 1'b0, accepted: 1'b0};
                            st_next = S_DONE;
                        end else begin
                            cur_next   = total_reg[IDX_W-1:0];
                            total_next = total_reg + 1'b1;
                            st_next    = S_A_SET;
                        end
                    end else if (in_cmd == CMD_QUERY) begin
                        st_next = S_Q_CHK;
                    end else if (in_cmd == CMD_CLEAR) begin
                        last_next     = '0;
                        total_next    = (IDX_W + 1)'(1);
                        cursor_next   = '0;
                        failed_next   = 1'b0;
                        qcount_next   = '0;
                        cnt_next      = '0;
                        clr_resp_next = 1'b1;
                        st_next       = S_CLR;
                    end else begin
                        res_next = '{states_used: 8'(total_reg), match_len: qcount_reg,
                                     found: 1'b0, accepted: 1'b0};
                        st_next = S_DONE;
                    end
                end
            end
            S_A_SET: begin
                l_we    = 1'b1;
                l_waddr = cur_reg;
                l_wdata = l_rdata + 1'b1;
                k_we    = 1'b1;
                k_waddr = cur_reg;
                k_wdata = '0;
                p_next  = last_reg;
                st_next = S_W_RD;
            end
            S_W_RD: begin
                st_next = S_W_CHK;
            end
            S_W_CHK: begin
                if (t_rdata != '0) begin
                    q_next  = IDX_W'(t_rdata - 1'b1);
                    st_next = S_F_LP;
                end else begin
                    t_we    = 1'b1;
                    t_wdata = {1'b0, cur_reg} + 1'b1;
                    if (p_reg == '0) begin
                        st_next = S_FIN;
                    end else begin
                        p_next  = k_rdata;
                        st_next = S_W_RD;
                    end
                end
            end
            S_F_LP: begin
                st_next = S_F_LQ;
            end
            S_F_LQ: begin
                lenp_next = l_rdata;
                l_raddr   = q_reg;
                st_next   = S_F_CMP;
            end
            S_F_CMP: begin
                k_raddr = q_reg;
                if ({1'b0, lenp_reg} + 1'b1 == {1'b0, l_rdata}) begin
                    k_we    = 1'b1;
                    k_waddr = cur_reg;
                    k_wdata = q_reg;
                    st_next = S_FIN;
                end else begin
                    clone_next = total_reg[IDX_W-1:0];
                    total_next = total_reg + 1'b1;
                    l_we       = 1'b1;
                    l_waddr    = total_reg[IDX_W-1:0];
                    l_wdata    = lenp_reg + 1'b1;
                    st_next    = S_C_LINK;
                end
            end
            S_C_LINK: begin
                k_we     = 1'b1;
                k_waddr  = clone_reg;
                k_wdata  = k_rdata;
                cnt_next = '0;
                st_next  = S_C_COPY;
            end
            S_C_COPY: begin
                t_raddr = {q_reg, cnt_reg[SYMBOL_BITS-1:0]};
                if (cnt_reg != '0) begin
                    t_we    = 1'b1;
                    t_waddr = {clone_reg, cnt_reg[SYMBOL_BITS-1:0] - 1'b1};
                    t_wdata = t_rdata;
                end
                if (cnt_reg == (ADDR_W + 1)'(ALPHA)) begin
                    st_next = S_R_RD;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_R_RD: begin
                st_next = S_R_CHK;
            end
            S_R_CHK: begin
                if (t_rdata == {1'b0, q_reg} + 1'b1) begin
                    t_we    = 1'b1;
                    t_wdata = {1'b0, clone_reg} + 1'b1;
                    if (p_reg == '0) begin
                        st_next = S_C_FIX;
                    end else begin
                        p_next  = k_rdata;
                        st_next = S_R_RD;
                    end
                end else begin
                    st_next = S_C_FIX;
                end
            end
            S_C_FIX: begin
                k_we    = 1'b1;
                k_waddr = q_reg;
                k_wdata = clone_reg;
                st_next = S_C_FIX2;
            end
            S_C_FIX2: begin
                k_we    = 1'b1;
                k_waddr = cur_reg;
                k_wdata = clone_reg;
                st_next = S_FIN;
            end
            S_FIN: begin
                last_next = cur_reg;
                res_next  = '{states_used: 8'(total_reg), match_len: qcount_reg,
                              found: 1'b0, accepted: 1'b1};
                st_next   = S_DONE;
            end
            S_Q_CHK: begin
                if (!failed_reg) begin
                    if (t_rdata != '0) begin
                        q_cursor = IDX_W'(t_rdata - 1'b1);
                        if (qcount_reg != 8'hFF) begin
                            q_count = qcount_reg + 1'b1;
                        end
                    end else begin
                        q_failed = 1'b1;
                    end
                end
                res_next = '{states_used: 8'(total_reg), match_len: q_count,
                             found: qend_reg & ~q_failed, accepted: 1'b1};
                if (qend_reg) begin
                    cursor_next = '0;
                    failed_next = 1'b0;
                    qcount_next = '0;
                end else begin
                    cursor_next = q_cursor;
                    failed_next = q_failed;
                    qcount_next = q_count;
                end
                st_next = S_DONE;
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    clr_resp_next = 1'b0;
                    st_next       = S_IDLE;
                end
            end
            default: begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= S_CLR;
            cnt_reg      <= '0;
            clr_resp_reg <= 1'b0;
            last_reg     <= '0;
            total_reg    <= (IDX_W + 1)'(1);
            cursor_reg   <= '0;
            failed_reg   <= 1'b0;
            qcount_reg   <= '0;
        end else begin
            st_reg       <= st_next;
            cnt_reg      <= cnt_next;
            clr_resp_reg <= clr_resp_next;
            last_reg     <= last_next;
            total_reg    <= total_next;
            cursor_reg   <= cursor_next;
            failed_reg   <= failed_next;
            qcount_reg   <= qcount_next;
        end
    end

    always_ff @(posedge aclk) begin
        sym_reg   <= sym_next;
        qend_reg  <= qend_next;
        cur_reg   <= cur_next;
        p_reg     <= p_next;
        q_reg     <= q_next;
        clone_reg <= clone_next;
        lenp_reg  <= lenp_next;
        res_reg   <= res_next;
    end

    assign res = res_reg;

endmodule

FILE: hw/rtl/suffix_automaton_builder_unit.sv
// Suffix automaton builder: a sequencer walks the transition, length and link memories one
// step a cycle to build the automaton online and answer substring queries; each result
// transaction is held in an output register. An append sets up the new state and walks the
// suffix links, adding the missing transition, until it reaches the root or an existing
// transition, whose target lengths it then compares; a clone copies the link and the row of
// 2^SYMBOL_BITS transitions, redirects transitions on a second walk and updates the links.
// A query looks up one transition; a refused append or an unknown command answers directly.
// After reset and after a clear command the transition memory is swept, one entry a cycle,
// over all 2^(clog2(MAX_STATES) + SYMBOL_BITS) entries (32768 at the defaults) before the
// next transaction is taken. While a result waits in the output register the sequencer
// holds the following result. Depends on sab_pkg and sab_seq.
module suffix_automaton_builder_unit
    import sab_pkg::*;
#(
    parameter int MAX_STATES  = 128,
    parameter int SYMBOL_BITS = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,  // symbol
    input  logic [1:0]                  s_tuser,  // cmd
    input  logic                        s_tlast,  // query_end
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [RESULT_BYTES*8-1:0]   m_tdata   // accepted, found, match_len, states_used
);

    logic        res_valid;
    logic        res_ready;
    sab_result_t res;
    logic        m_tvalid_reg;
    logic [RESULT_BYTES*8-1:0] m_tdata_reg;

    sab_seq #(.MAX_STATES(MAX_STATES), .SYMBOL_BITS(SYMBOL_BITS)) u_seq (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_cmd(s_tuser), .in_symbol(s_tdata), .in_qend(s_tlast),
        .res_valid(res_valid), .res_ready(res_ready), .res(res)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_tdata_reg <= (RESULT_BYTES * 8)'(res);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: hw/rtl/sab_checker.sv
// Port-level checker of the suffix automaton builder, bound to the top level.
// Depends on suffix_automaton_builder_unit_defines.svh.
`include "suffix_automaton_builder_unit_defines.svh"

module sab_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    `SAB_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `SAB_ASSERT_NXT(a_hold_on_stall, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `SAB_ASSERT_IMP(a_found_implies_accepted, aclk, aresetn, m_tvalid && m_tdata[1], m_tdata[0])

endmodule

bind suffix_automaton_builder_unit sab_checker u_sab_checker (.*);
